// ----- rtl/gqlay_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gqlay_pkg
// Types, constants and helpers shared by the glyph quad layout block.
// ----------------------------------------------------------------------------
package gqlay_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);

  localparam int TEX_SIZE_W  = 13;
  localparam int TEXEL_W     = 13;
  localparam int TEX_COORD_W = 17;
  localparam int POS_W       = 16;
  localparam int WIDE_W      = 18;

  localparam int DIV_QBITS   = 18;
  localparam int DIV_STEPS   = 3;
  localparam int DIV_ITERS   = DIV_QBITS / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_ITERS);
  localparam int DIV_REM_W   = TEX_SIZE_W + 1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BASE_CODE    = 8'd65;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic REG_TEX_W = 1'b0;
  localparam logic REG_TEX_H = 1'b1;

  localparam logic [TEX_SIZE_W-1:0] TEX_SIZE_RESET = 13'd256;

  localparam logic [2:0] LAST_CORNER = 3'd5;
  // Per corner in the order LT,RB,LB,LT,RT,RB: 1 selects right or bottom.
  localparam logic [5:0] HSEL = 6'b110010;
  localparam logic [5:0] VSEL = 6'b100110;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } gqlay_state_t;

  typedef struct packed {
    logic              opcode;
    logic              first;
    logic [7:0]        glyph_code;
    logic [11:0]       src_x;
    logic [11:0]       src_y;
    logic [7:0]        glyph_w;
    logic [7:0]        glyph_h;
    logic signed [7:0] x_off;
    logic signed [7:0] y_off;
    logic [7:0]        x_adv;
  } gqlay_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TEX_COORD_W-1:0]  tex_u;
    logic [TEX_COORD_W-1:0]  tex_v;
    logic [2:0]              corner;
    logic                    last;
  } gqlay_out_t;

  typedef struct packed {
    logic [7:0]        x_adv;
    logic signed [7:0] y_off;
    logic signed [7:0] x_off;
    logic [7:0]        glyph_h;
    logic [7:0]        glyph_w;
    logic [11:0]       src_y;
    logic [11:0]       src_x;
  } gqlay_glyph_t;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gqlay_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gqlay_div
// Texture coordinate divider: round(texel * 65536 / size), saturated to
// Q1.16, found by restoring division with three quotient bits per cycle.
// ----------------------------------------------------------------------------
module gqlay_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [gqlay_pkg::TEXEL_W-1:0]      texel,
  input  wire logic [gqlay_pkg::TEX_SIZE_W-1:0]   size,
  output logic                                    done,
  output logic [gqlay_pkg::TEX_COORD_W-1:0]       quot
);
  import gqlay_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIV_REM_W-1:0]    dvs_r, rem_r, rem_nxt;
  logic [DIV_QBITS-1:0]    low_r, low_nxt, q_r, q_nxt;
  logic                    ovf_r;
  logic [TEX_SIZE_W-1:0]   size_eff;
  logic [DIV_REM_W-1:0]    dvs_init;
  logic [DIV_REM_W:0]      trial;

  assign size_eff = (size == '0) ? TEX_SIZE_W'(1) : size;
  assign dvs_init = {size_eff, 1'b0};
  assign done     = busy_r && (cnt_r == DIV_CNT_W'(DIV_ITERS - 1));
  assign quot     = ovf_r ? '1 : q_r[DIV_QBITS-1:1];

  always_comb begin
    rem_nxt = rem_r;
    low_nxt = low_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial   = {rem_nxt, low_nxt[DIV_QBITS-1]};
      low_nxt = {low_nxt[DIV_QBITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial = trial - {1'b0, dvs_r};
        q_nxt = {q_nxt[DIV_QBITS-2:0], 1'b1};
      end else begin
        q_nxt = {q_nxt[DIV_QBITS-2:0], 1'b0};
      end
      rem_nxt = trial[DIV_REM_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= dvs_init;
      ovf_r <= ({1'b0, texel} >= dvs_init);
      rem_r <= {1'b0, texel};
      low_r <= {{(DIV_QBITS - DIV_REM_W){1'b0}}, dvs_init};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/glyph_quad_layout.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Bitmap-font text layout: loads glyph descriptors into a table and turns
// each drawn character into six triangle vertices with texture coordinates.
// ----------------------------------------------------------------------------
// A load transfer produces no vertex.
// A draw transfer reads the glyph memory, then runs the texture coordinate
// dividers; its first vertex is registered once the dividers are done.
// Vertices then leave one per cycle while out_ready does not stall the
// output register; in_ready stays low until the last vertex is loaded.
// Reset clears the glyph valid bits, pen and line offset; texture sizes are 256.
module glyph_quad_layout (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire gqlay_pkg::gqlay_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gqlay_pkg::gqlay_out_t      out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [2:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import gqlay_pkg::*;

  gqlay_state_t state_r, state_nxt;

  logic [TEX_SIZE_W-1:0] tex_w_r, tex_h_r;
  logic                  cfg_wr;

  gqlay_glyph_t          glyph_mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] glyph_vld_r;
  gqlay_glyph_t          rd_data_r;
  logic                  rd_vld_r;
  gqlay_glyph_t          glyph;
  gqlay_glyph_t          wr_entry;
  logic [GLYPH_AW-1:0]   addr;
  logic                  in_range;

  logic in_fire, load_fire, draw_fire, newline;

  logic signed [POS_W-1:0] pen_x_r, line_r, pen_base, line_base, line_nxt;
  logic [7:0]              h_a_r;

  logic signed [WIDE_W-1:0] pen18, line18, left18, right18, top18, bottom18;
  logic signed [WIDE_W-1:0] pen_adv18, line_add18;
  logic signed [POS_W-1:0]  left_r, right_r, top_r, bottom_r;

  logic                   div_start, geo_en, out_load;
  logic [3:0]             div_done;
  logic [TEXEL_W-1:0]     texel [4];
  logic [TEX_COORD_W-1:0] quot [4];

  logic [2:0]  corner_r;
  logic        out_valid_r;
  gqlay_out_t  out_data_r;
  gqlay_out_t  vertex;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TEX_H) ? {19'b0, tex_h_r} : {19'b0, tex_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= TEX_SIZE_RESET;
      tex_h_r <= TEX_SIZE_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TEX_W) begin
        tex_w_r <= cfg_pwdata[TEX_SIZE_W-1:0];
      end else begin
        tex_h_r <= cfg_pwdata[TEX_SIZE_W-1:0];
      end
    end
  end

  // Input transfer decode.
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_data.opcode == OP_LOAD);
  assign draw_fire = in_fire && (in_data.opcode == OP_DRAW);
  assign newline   = (in_data.glyph_code == NEWLINE_CODE);
  assign addr      = GLYPH_AW'(in_data.glyph_code);
  assign in_range  = (32'(in_data.glyph_code) < GLYPH_COUNT);

  assign wr_entry.x_adv   = in_data.x_adv;
  assign wr_entry.y_off   = in_data.y_off;
  assign wr_entry.x_off   = in_data.x_off;
  assign wr_entry.glyph_h = in_data.glyph_h;
  assign wr_entry.glyph_w = in_data.glyph_w;
  assign wr_entry.src_y   = in_data.src_y;
  assign wr_entry.src_x   = in_data.src_x;

  // Glyph memory with one valid bit per entry.
  always_ff @(posedge clk) begin
    if (load_fire && in_range) begin
      glyph_mem[addr] <= wr_entry;
    end
    if (draw_fire) begin
      rd_data_r <= glyph_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_vld_r <= '0;
      rd_vld_r    <= 1'b0;
      h_a_r       <= '0;
    end else begin
      if (load_fire && in_range) begin
        glyph_vld_r[addr] <= 1'b1;
      end
      if (load_fire && (in_data.glyph_code == BASE_CODE)) begin
        h_a_r <= in_data.glyph_h;
      end
      if (draw_fire) begin
        rd_vld_r <= in_range && glyph_vld_r[addr];
      end
    end
  end

  assign glyph = rd_vld_r ? rd_data_r : '0;

  // Pen and line offset at the start of a draw.
  assign pen_base   = (in_data.first || newline) ? '0 : pen_x_r;
  assign line_base  = in_data.first ? '0 : line_r;
  assign line_add18 = {{2{line_base[POS_W-1]}}, line_base} + {9'b0, h_a_r, 1'b0};
  assign line_nxt   = newline ? sat16(line_add18) : line_base;

  // Quad geometry in half pixels.
  assign pen18     = {{2{pen_x_r[POS_W-1]}}, pen_x_r};
  assign line18    = {{2{line_r[POS_W-1]}}, line_r};
  assign left18    = pen18 + {{9{glyph.x_off[7]}}, glyph.x_off, 1'b0};
  assign right18   = left18 + {9'b0, glyph.glyph_w, 1'b0};
  assign top18     = {10'b0, h_a_r} - {{9{glyph.y_off[7]}}, glyph.y_off, 1'b0} - line18;
  assign bottom18  = top18 - {9'b0, glyph.glyph_h, 1'b0};
  assign pen_adv18 = pen18 + {9'b0, glyph.x_adv, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      line_r  <= '0;
    end else if (draw_fire) begin
      pen_x_r <= pen_base;
      line_r  <= line_nxt;
    end else if (geo_en) begin
      pen_x_r <= sat16(pen_adv18);
    end
  end

  always_ff @(posedge clk) begin
    if (geo_en) begin
      left_r   <= sat16(left18);
      right_r  <= sat16(right18);
      top_r    <= sat16(top18);
      bottom_r <= sat16(bottom18);
    end
  end

  // Texture coordinate dividers: left, right, top, bottom.
  assign texel[0] = {1'b0, glyph.src_x};
  assign texel[1] = {1'b0, glyph.src_x} + {5'b0, glyph.glyph_w};
  assign texel[2] = {1'b0, glyph.src_y};
  assign texel[3] = {1'b0, glyph.src_y} + {5'b0, glyph.glyph_h};

  for (genvar i = 0; i < 4; i++) begin : g_div
    gqlay_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .texel (texel[i]),
      .size  ((i < 2) ? tex_w_r : tex_h_r),
      .done  (div_done[i]),
      .quot  (quot[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (draw_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done[0]) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && (corner_r == LAST_CORNER)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    div_start = 1'b0;
    geo_en    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_READ: begin
        div_start = 1'b1;
        geo_en    = 1'b1;
      end
      ST_EMIT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Vertex output register.
  assign vertex.pos_x  = HSEL[corner_r] ? right_r : left_r;
  assign vertex.pos_y  = VSEL[corner_r] ? bottom_r : top_r;
  assign vertex.tex_u  = HSEL[corner_r] ? quot[1] : quot[0];
  assign vertex.tex_v  = VSEL[corner_r] ? quot[3] : quot[2];
  assign vertex.corner = corner_r;
  assign vertex.last   = (corner_r == LAST_CORNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      corner_r    <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        corner_r    <= (corner_r == LAST_CORNER) ? '0 : corner_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= vertex;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_draw_reads: assert property (@(posedge clk) disable iff (!rst_n)
    draw_fire |=> (state_r == ST_READ))
    else $error("draw transfer did not start a glyph read");

  a_base_height: assert property (@(posedge clk) disable iff (!rst_n)
    (load_fire && (in_data.glyph_code == BASE_CODE)) |=> (h_a_r == $past(in_data.glyph_h)))
    else $error("base glyph height not captured");

  a_first_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (draw_fire && in_data.first && !newline) |=> ((pen_x_r == '0) && (line_r == '0)))
    else $error("first character did not reset pen and line offset");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (corner_r != LAST_CORNER)) |=> (out_data_r.corner == $past(corner_r)))
    else $error("vertex corner out of order");

endmodule
`default_nettype wire
